/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFGL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFGL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sfgl_pkg.sv */
// shared constants, word types and state codes for the gain limiter
package sfgl_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 22;
  localparam int FRAC_BITS      = SAMPLE_BITS - 1;
  localparam int GAIN_BITS      = GAIN_FRAC_BITS + 4;
  localparam int OPND_BITS      = (SAMPLE_BITS + 1 > GAIN_FRAC_BITS + 2) ?
                                  SAMPLE_BITS + 1 : GAIN_FRAC_BITS + 2;
  localparam int MAG_BITS       = 2 * OPND_BITS;
  localparam int PROD_BITS      = MAG_BITS + 1;
  localparam int CNT_BITS       = $clog2(OPND_BITS + 1);
  localparam int DIV_BITS       = 8;

  localparam longint SIN4_Q31 = 64'd1625220983;
  localparam longint S4_MAG   = SIN4_Q31 >> (31 - FRAC_BITS);
  localparam longint OUT_LIM  = ((longint'(1) << FRAC_BITS) * 9999) / 10000;
  localparam longint ONE_F    = longint'(1) << FRAC_BITS;

  localparam logic signed [GAIN_BITS-1:0] GAIN_ONE =
    GAIN_BITS'(longint'(1) << GAIN_FRAC_BITS);
  localparam logic signed [GAIN_BITS-1:0] GAIN_MIN =
    GAIN_BITS'(longint'(1) << (GAIN_FRAC_BITS - 7));
  localparam logic signed [GAIN_BITS-1:0] GAIN_MAX =
    GAIN_BITS'(longint'(2) << GAIN_FRAC_BITS);

  localparam logic [DIV_BITS-1:0] DIV_SIX      = DIV_BITS'(6);
  localparam logic [DIV_BITS-1:0] DIV_ONE_TWENTY = DIV_BITS'(120);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_result;
    logic signed [SAMPLE_BITS-1:0] right_result;
    logic                          block_end_out;
  } out_word_t;

  typedef enum logic {SU_MUL, SU_DIV} su_op_t;

  typedef struct packed {
    logic                 start;
    su_op_t               op;
    logic                 neg;
    logic [OPND_BITS-1:0] opa;
    logic [OPND_BITS-1:0] opb;
  } su_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_Y, ST_Y2, ST_Y4, ST_A2, ST_A3, ST_A5,
    ST_D6, ST_D120, ST_DELTA, ST_OUT
  } sfgl_state_t;

endpackage

/* rtl/sfgl_serial_unit.sv */
// bit-serial shift-add multiplier and restoring divider by a small constant
module sfgl_serial_unit import sfgl_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  su_req_t                     req,
  output logic                        done,
  output logic signed [PROD_BITS-1:0] result
);

  logic                        busy_r;
  logic                        fin_r;
  logic                        done_r;
  logic [CNT_BITS-1:0]         cnt_r;
  su_op_t                      op_r;
  logic                        neg_r;
  logic [MAG_BITS-1:0]         acc_r;
  logic [MAG_BITS-1:0]         mcand_r;
  logic [OPND_BITS-1:0]        mplier_r;
  logic [DIV_BITS-1:0]         rem_r;
  logic [DIV_BITS-1:0]         dvsr_r;
  logic signed [PROD_BITS-1:0] result_r;
  logic [DIV_BITS:0]           rem_shift;
  logic                        qbit;
  logic signed [PROD_BITS-1:0] acc_s;

  // one divider step: bring down the next dividend bit
  assign rem_shift = {rem_r, mplier_r[OPND_BITS-1]};
  assign qbit      = (rem_shift >= {1'b0, dvsr_r});
  assign acc_s     = $signed({1'b0, acc_r});

  // control: busy over one pass of the operand bits, then fin_r, then done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(OPND_BITS - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // datapath: one multiplier bit or one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      op_r     <= req.op;
      neg_r    <= req.neg;
      acc_r    <= '0;
      rem_r    <= '0;
      mcand_r  <= MAG_BITS'(req.opa);
      dvsr_r   <= req.opb[DIV_BITS-1:0];
      mplier_r <= (req.op == SU_MUL) ? req.opb : req.opa;
    end else if (busy_r) begin
      if (op_r == SU_MUL) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
      end else begin
        rem_r    <= qbit ? DIV_BITS'(rem_shift - {1'b0, dvsr_r}) : rem_shift[DIV_BITS-1:0];
        acc_r    <= {acc_r[MAG_BITS-2:0], qbit};
        mplier_r <= mplier_r << 1;
      end
    end
    if (fin_r) begin
      result_r <= neg_r ? -acc_s : acc_s;
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

/* rtl/stereo_feedback_gain_limiter_unit.sv */
// stereo feedback gain-rider limiter, top level with step sequencer
//
//  channel | ports                       | moves
//  --------+-----------------------------+-----------------------------
//  input   | in_valid in_stall in_data   | one stereo frame per word
//  output  | out_valid out_stall out_data| limited frame per word
//
// each frame runs up to 18 serial operations (9 per channel) on one shared
// bit-serial unit, 10 fewer when both channels take the loud path.
// reset is synchronous, active low; gain returns to 1.0.
// the result register holds under out_stall; a new frame is taken meanwhile
// and the sequencer waits at its end until the result register is free.
module stereo_feedback_gain_limiter_unit import sfgl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  sfgl_state_t st_r, st_nxt;
  logic        issued_r;
  logic        ch_r;
  su_req_t     req;
  logic        su_done;
  logic signed [PROD_BITS-1:0] su_res;

  logic signed [SAMPLE_BITS-1:0] xl_r, xr_r, y_r, resl_r, resr_r;
  logic                          be_r;
  logic signed [GAIN_BITS-1:0]   gain_r;
  logic signed [GAIN_BITS-1:0]   gmul_r;
  logic [SAMPLE_BITS-1:0]        y2_r, y4_r, a2_r, a3_r, a5_r, q6_r;
  logic signed [SAMPLE_BITS:0]   s_r;
  logic                          out_valid_r;
  out_word_t                     out_data_r;

  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic signed [OPND_BITS:0]     x_w, y_w, s_w;
  logic [OPND_BITS-1:0]          x_mag, y_mag, s_mag;
  logic [OPND_BITS+1:0]          a_w;
  logic                          a_big;
  logic [OPND_BITS-1:0]          a_op;
  logic signed [SAMPLE_BITS-1:0] y_new;
  logic signed [GAIN_BITS-1:0]   gain_clamped;

  // 2y clamped to the output limit
  function automatic logic signed [SAMPLE_BITS-1:0] limit_out(
    input logic signed [SAMPLE_BITS-1:0] y);
    logic signed [SAMPLE_BITS:0] v;
    logic signed [SAMPLE_BITS:0] lim;
    v   = (SAMPLE_BITS+1)'(y) <<< 1;
    lim = (SAMPLE_BITS+1)'(OUT_LIM);
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return SAMPLE_BITS'(v);
  endfunction

  // operand magnitudes
  assign x_cur = ch_r ? xr_r : xl_r;
  assign x_w   = (OPND_BITS+1)'(x_cur);
  assign x_mag = OPND_BITS'(x_w < 0 ? -x_w : x_w);
  assign y_w   = (OPND_BITS+1)'(y_r);
  assign y_mag = OPND_BITS'(y_w < 0 ? -y_w : y_w);
  assign s_w   = (OPND_BITS+1)'(s_r);
  assign s_mag = OPND_BITS'(s_w < 0 ? -s_w : s_w);
  assign a_w   = {y_mag, 2'b00};
  assign a_big = (a_w > (OPND_BITS+2)'(ONE_F));
  assign a_op  = OPND_BITS'(a_w);
  assign y_new = SAMPLE_BITS'(su_res >>> (GAIN_FRAC_BITS + 1));

  // gain clamp applied at frame start
  always_comb begin
    gain_clamped = gain_r;
    if (gain_r < GAIN_MIN) begin
      gain_clamped = GAIN_MIN;
    end else if (gain_r > GAIN_MAX) begin
      gain_clamped = GAIN_MAX;
    end
  end

  sfgl_serial_unit u_su (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .done   (su_done),
    .result (su_res)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // next state and serial unit request
  always_comb begin
    st_nxt    = st_r;
    req       = '0;
    req.op    = SU_MUL;
    req.start = (st_r != ST_IDLE) && (st_r != ST_OUT) && !issued_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) st_nxt = ST_Y;
      end
      ST_Y: begin
        req.opa = x_mag;
        req.opb = OPND_BITS'($unsigned(gmul_r));
        req.neg = x_cur < 0;
        if (su_done) st_nxt = ST_Y2;
      end
      ST_Y2: begin
        req.opa = y_mag;
        req.opb = y_mag;
        if (su_done) st_nxt = ST_Y4;
      end
      ST_Y4: begin
        req.opa = OPND_BITS'(y2_r);
        req.opb = OPND_BITS'(y2_r);
        if (su_done) st_nxt = a_big ? ST_DELTA : ST_A2;
      end
      ST_A2: begin
        req.opa = a_op;
        req.opb = a_op;
        if (su_done) st_nxt = ST_A3;
      end
      ST_A3: begin
        req.opa = OPND_BITS'(a2_r);
        req.opb = a_op;
        if (su_done) st_nxt = ST_A5;
      end
      ST_A5: begin
        req.opa = OPND_BITS'(a3_r);
        req.opb = OPND_BITS'(a2_r);
        if (su_done) st_nxt = ST_D6;
      end
      ST_D6: begin
        req.op  = SU_DIV;
        req.opa = OPND_BITS'(a3_r);
        req.opb = OPND_BITS'(DIV_SIX);
        if (su_done) st_nxt = ST_D120;
      end
      ST_D120: begin
        req.op  = SU_DIV;
        req.opa = OPND_BITS'(a5_r);
        req.opb = OPND_BITS'(DIV_ONE_TWENTY);
        if (su_done) st_nxt = ST_DELTA;
      end
      ST_DELTA: begin
        req.opa = s_mag;
        req.opb = OPND_BITS'(y4_r);
        req.neg = s_r < 0;
        if (su_done) st_nxt = ch_r ? ST_OUT : ST_Y;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r    <= 1'b0;
      ch_r        <= 1'b0;
      gain_r      <= GAIN_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (req.start) begin
        issued_r <= 1'b1;
      end else if (su_done) begin
        issued_r <= 1'b0;
      end
      if (st_r == ST_IDLE && in_valid) begin
        ch_r   <= 1'b0;
        gain_r <= gain_clamped;
      end
      if (st_r == ST_DELTA && su_done) begin
        ch_r   <= 1'b1;
        gain_r <= gain_r + GAIN_BITS'(su_res >>> (2 * FRAC_BITS - GAIN_FRAC_BITS));
      end
      if (st_r == ST_OUT && st_nxt == ST_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // step results
  always_ff @(posedge clk) begin
    // both channels scale by the clamped gain taken at frame start
    if (st_r == ST_IDLE && in_valid) begin
      xl_r   <= in_data.left_sample;
      xr_r   <= in_data.right_sample;
      be_r   <= in_data.block_end;
      gmul_r <= gain_clamped;
    end
    if (su_done) begin
      unique case (st_r)
        ST_Y: begin
          y_r <= y_new;
          if (ch_r) resr_r <= limit_out(y_new);
          else      resl_r <= limit_out(y_new);
        end
        ST_Y2: y2_r <= SAMPLE_BITS'(su_res >>> FRAC_BITS);
        ST_Y4: begin
          y4_r <= SAMPLE_BITS'(su_res >>> FRAC_BITS);
          if (a_big) s_r <= -(SAMPLE_BITS+1)'(S4_MAG);
        end
        ST_A2:   a2_r <= SAMPLE_BITS'(su_res >>> FRAC_BITS);
        ST_A3:   a3_r <= SAMPLE_BITS'(su_res >>> FRAC_BITS);
        ST_A5:   a5_r <= SAMPLE_BITS'(su_res >>> FRAC_BITS);
        ST_D6:   q6_r <= SAMPLE_BITS'(su_res);
        ST_D120: s_r  <= $signed({1'b0, SAMPLE_BITS'(a_w)}) - $signed({1'b0, q6_r})
                         + $signed({1'b0, SAMPLE_BITS'(su_res)});
        default: ;
      endcase
    end
    if (st_r == ST_OUT && st_nxt == ST_IDLE) begin
      out_data_r.left_result   <= resl_r;
      out_data_r.right_result  <= resr_r;
      out_data_r.block_end_out <= be_r;
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/sfgl_checker.sv */
// port-level checks for the gain limiter, bound to the top level
`include "assert_macros.svh"

module sfgl_checker import sfgl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  localparam logic signed [SAMPLE_BITS-1:0] LIM = SAMPLE_BITS'(OUT_LIM);

  // a stalled result word holds
  `SFGL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "out word changed under stall")
  // a frame in work blocks the next one
  `SFGL_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while busy")
  // results stay inside the output limit
  `SFGL_ASSERT(a_left_lim, out_valid, out_data.left_result <= LIM && out_data.left_result >= -LIM, "left out of limit")
  `SFGL_ASSERT(a_right_lim, out_valid, out_data.right_result <= LIM && out_data.right_result >= -LIM, "right out of limit")

endmodule

bind stereo_feedback_gain_limiter_unit sfgl_checker u_sfgl_checker (.*);
